@@ hw/rtl/srsw_pkg.sv @@
package srsw_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = 5;
    localparam int WIN_W      = 6;
    localparam int SEQ_W      = 16;
    localparam int CNT_W      = 17;
    localparam int BYTES_W    = 27;
    localparam int LEN_W      = 11;
    localparam int SEG_SHIFT  = 10;
    localparam int MOD_STEPS  = 17;

    localparam logic [BYTES_W-1:0] BYTES_CAP   = 27'd67108864;
    localparam logic [LEN_W-1:0]   SEG_LEN     = 11'd1024;
    localparam logic [2:0]         TAG_ACK     = 3'b010;
    localparam logic [WIN_W-1:0]   WIN_MAX     = 6'd32;
    localparam logic [WIN_W-1:0]   WIN_MIN     = 6'd1;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_BYTES   = 2'd2;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_ACK   = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RETX = 2'd1,
        ACT_DONE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MS_NEXT  = 2'd0,
        MS_ASEQ  = 2'd1,
        MS_ACKED = 2'd2
    } t_modsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEND_MOD,
        ST_SEND,
        ST_BRANCH,
        ST_ACK_MOD,
        ST_ACK_MARK,
        ST_SLIDE_MOD,
        ST_SLIDE,
        ST_ACK_DONE,
        ST_SCAN_MOD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    mod_start;
        t_modsel mod_sel;
        logic    set_ptr;
        logic    emit;
        t_action emit_act;
        logic    set_done;
        logic    do_send;
        logic    do_mark;
        logic    slide_step;
        logic    scan_step;
        logic    flush;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic ack_good;
        logic in_range;
        logic complete;
        logic done_rep;
        logic can_send;
        logic slide_go;
        logic scan_more;
        logic scan_hit;
        logic emit_ok;
        logic pend_valid;
        logic out_free;
        logic mod_done;
    } t_sts;

endpackage

@@ hw/rtl/srsw_mod.sv @@
module srsw_mod
    import srsw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_dividend,
    input  logic [WIN_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_rem
);

    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_div, n_div;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [WIN_W-1:0]  trial;

    assign trial = {r_rem, r_div[CNT_W-1]};

    always_comb begin
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        if (i_start) begin
            n_rem = '0;
            n_div = i_dividend;
            n_cnt = SLOT_W'(MOD_STEPS);
        end else if (r_cnt != '0) begin
            n_div = {r_div[CNT_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (trial >= i_divisor) begin
                n_rem = SLOT_W'(trial - i_divisor);
            end else begin
                n_rem = trial[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

@@ hw/rtl/srsw_ctrl.sv @@
module srsw_ctrl
    import srsw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (i_sts.op == OP_NONE || i_sts.op == OP_START) begin
                    n_state = ST_IDLE;
                end else if (i_sts.complete) begin
                    n_state = ST_FLUSH;
                end else if (i_sts.can_send) begin
                    n_state = ST_SEND_MOD;
                end else begin
                    n_state = ST_BRANCH;
                end
            end
            ST_SEND_MOD: begin
                if (i_sts.mod_done) n_state = ST_SEND;
            end
            ST_SEND: begin
                if (i_sts.emit_ok) n_state = ST_BRANCH;
            end
            ST_BRANCH: begin
                priority if (i_sts.op == OP_ACK) begin
                    priority if (!i_sts.ack_good) n_state = ST_FLUSH;
                    else if (i_sts.in_range)      n_state = ST_ACK_MOD;
                    else                          n_state = ST_SLIDE_MOD;
                end else begin
                    n_state = ST_SCAN_MOD;
                end
            end
            ST_ACK_MOD: begin
                if (i_sts.mod_done) n_state = ST_ACK_MARK;
            end
            ST_ACK_MARK: n_state = ST_SLIDE_MOD;
            ST_SLIDE_MOD: begin
                if (i_sts.mod_done) n_state = ST_SLIDE;
            end
            ST_SLIDE: begin
                if (!i_sts.slide_go) n_state = ST_ACK_DONE;
            end
            ST_ACK_DONE: begin
                if (!(i_sts.complete && !i_sts.done_rep) || i_sts.emit_ok) n_state = ST_FLUSH;
            end
            ST_SCAN_MOD: begin
                if (i_sts.mod_done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_sts.scan_more) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mod_sel = MS_ACKED;
        o_cmd.emit_act = ACT_SEND;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: begin
                priority if (i_sts.op == OP_NONE) begin
                end else if (i_sts.op == OP_START) begin
                    o_cmd.clear = 1'b1;
                end else if (i_sts.complete) begin
                    if (!i_sts.done_rep) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_act = ACT_DONE;
                        o_cmd.set_done = 1'b1;
                    end
                end else if (i_sts.can_send) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel = MS_NEXT;
                end else begin
                end
            end
            ST_SEND: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_act = ACT_SEND;
                    o_cmd.do_send = 1'b1;
                end
            end
            ST_BRANCH: begin
                if (i_sts.op == OP_ACK) begin
                    if (i_sts.ack_good) begin
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_sel = i_sts.in_range ? MS_ASEQ : MS_ACKED;
                    end
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel = MS_ACKED;
                end
            end
            ST_SEND_MOD, ST_ACK_MOD, ST_SLIDE_MOD, ST_SCAN_MOD: begin
                o_cmd.set_ptr = i_sts.mod_done;
            end
            ST_ACK_MARK: begin
                o_cmd.do_mark = 1'b1;
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_sel = MS_ACKED;
            end
            ST_SLIDE: begin
                o_cmd.slide_step = i_sts.slide_go;
            end
            ST_ACK_DONE: begin
                if (i_sts.complete && !i_sts.done_rep && i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_act = ACT_DONE;
                    o_cmd.set_done = 1'b1;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_more) begin
                    if (i_sts.scan_hit) begin
                        if (i_sts.emit_ok) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.emit_act = ACT_RETX;
                            o_cmd.scan_step = 1'b1;
                        end
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = i_sts.pend_valid && i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/srsw_dp.sv @@
module srsw_dp
    import srsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_time,
    input  logic [SEQ_W-1:0]   i_ack_seq,
    input  logic [2:0]         i_ack_tag,
    input  logic               i_ack_checksum_ok,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_action,
    output logic [SEQ_W-1:0]   o_seq,
    output logic [LEN_W-1:0]   o_payload_length,
    output logic               o_last
);

    logic [WIN_W-1:0]   r_window;
    logic [31:0]        r_timeout;
    logic [BYTES_W-1:0] r_bytes;

    logic [1:0]         r_op;
    logic [31:0]        r_now;
    logic [SEQ_W-1:0]   r_aseq;
    logic               r_ack_good;

    logic [CNT_W-1:0]      r_acked;
    logic [CNT_W-1:0]      r_next;
    logic [MAX_WINDOW-1:0] r_marks;
    logic [MAX_WINDOW-1:0] r_active;
    logic [31:0]           r_stamp [MAX_WINDOW];
    logic                  r_done_rep;
    logic [SLOT_W-1:0]     r_ptr;
    logic [WIN_W-1:0]      r_cnt;

    logic               r_pend_valid;
    logic [1:0]         r_pend_act;
    logic [SEQ_W-1:0]   r_pend_seq;
    logic [LEN_W-1:0]   r_pend_len;

    logic               r_out_valid;
    logic [1:0]         r_out_act;
    logic [SEQ_W-1:0]   r_out_seq;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_last;

    logic [WIN_W-1:0]   w_eff;
    logic [BYTES_W-1:0] bytes_cap;
    logic [CNT_W-1:0]   segs;
    logic [LEN_W-1:0]   send_len;
    logic [CNT_W-1:0]   mod_dividend;
    logic               mod_done;
    logic [SLOT_W-1:0]  mod_rem;
    logic [SLOT_W-1:0]  ptr_inc;
    logic [31:0]        age;
    logic               out_free;
    logic [1:0]         new_act;
    logic [SEQ_W-1:0]   new_seq;
    logic [LEN_W-1:0]   new_len;
    logic [CNT_W-1:0]   retx_seq;

    always_comb begin
        priority if (r_window == '0)    w_eff = WIN_MIN;
        else if (r_window > WIN_MAX)    w_eff = WIN_MAX;
        else                            w_eff = r_window;
    end

    assign bytes_cap = (r_bytes > BYTES_CAP) ? BYTES_CAP : r_bytes;
    assign segs = CNT_W'(bytes_cap[BYTES_W-1:SEG_SHIFT])
                + CNT_W'(|bytes_cap[SEG_SHIFT-1:0]);
    always_comb begin
        if (r_next == segs - 1'b1 && bytes_cap[SEG_SHIFT-1:0] != '0) begin
            send_len = LEN_W'(bytes_cap[SEG_SHIFT-1:0]);
        end else begin
            send_len = SEG_LEN;
        end
    end

    always_comb begin
        unique case (i_cmd.mod_sel)
            MS_NEXT:  mod_dividend = r_next;
            MS_ASEQ:  mod_dividend = CNT_W'(r_aseq);
            MS_ACKED: mod_dividend = r_acked;
            default:  mod_dividend = r_acked;
        endcase
    end

    srsw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (w_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign ptr_inc  = (WIN_W'(r_ptr) + 1'b1 == w_eff) ? '0 : r_ptr + 1'b1;
    assign age      = r_now - r_stamp[r_ptr];
    assign out_free = !r_out_valid || i_out_ready;
    assign retx_seq = r_acked + CNT_W'(r_cnt);

    assign o_sts.op         = t_op'(r_op);
    assign o_sts.ack_good   = r_ack_good;
    assign o_sts.in_range   = (CNT_W'(r_aseq) >= r_acked) && (CNT_W'(r_aseq) < r_next);
    assign o_sts.complete   = (r_acked == segs);
    assign o_sts.done_rep   = r_done_rep;
    assign o_sts.can_send   = (r_next < segs) && ((r_next - r_acked) < CNT_W'(w_eff));
    assign o_sts.slide_go   = (r_cnt < w_eff) && (r_acked < r_next) && r_marks[r_ptr];
    assign o_sts.scan_more  = (r_cnt < w_eff);
    assign o_sts.scan_hit   = r_active[r_ptr] && (age > r_timeout);
    assign o_sts.emit_ok    = !r_pend_valid || out_free;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;
    assign o_sts.mod_done   = mod_done;

    always_comb begin
        new_act = i_cmd.emit_act;
        new_seq = '0;
        new_len = '0;
        unique case (i_cmd.emit_act)
            ACT_SEND: begin
                new_seq = r_next[SEQ_W-1:0];
                new_len = send_len;
            end
            ACT_RETX: new_seq = retx_seq[SEQ_W-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= 6'd4;
            r_timeout    <= 32'd1000;
            r_bytes      <= '0;
            r_acked      <= '0;
            r_next       <= '0;
            r_marks      <= '0;
            r_active     <= '0;
            r_done_rep   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WINDOW:  r_window  <= i_cfg_data[WIN_W-1:0];
                    REG_TIMEOUT: r_timeout <= i_cfg_data;
                    REG_BYTES:   r_bytes   <= i_cfg_data[BYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear) begin
                r_acked    <= '0;
                r_next     <= '0;
                r_marks    <= '0;
                r_active   <= '0;
                r_done_rep <= 1'b0;
            end
            if (i_cmd.set_done) r_done_rep <= 1'b1;
            if (i_cmd.do_send) begin
                r_active[r_ptr] <= 1'b1;
                r_next <= r_next + 1'b1;
            end
            if (i_cmd.do_mark) begin
                r_marks[r_ptr]  <= 1'b1;
                r_active[r_ptr] <= 1'b0;
            end
            if (i_cmd.slide_step) begin
                r_marks[r_ptr] <= 1'b0;
                r_acked <= r_acked + 1'b1;
            end

            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.emit && r_pend_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load) begin
            r_op       <= i_op;
            r_now      <= i_now_time;
            r_aseq     <= i_ack_seq;
            r_ack_good <= (i_ack_tag == TAG_ACK) && i_ack_checksum_ok;
        end
        if (i_cmd.set_ptr) begin
            r_ptr <= mod_rem;
            r_cnt <= '0;
        end else if (i_cmd.slide_step || i_cmd.scan_step) begin
            r_ptr <= ptr_inc;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.do_send) r_stamp[r_ptr] <= r_now;
        if (i_cmd.scan_step && o_sts.scan_hit) r_stamp[r_ptr] <= r_now;
        if (i_cmd.emit) begin
            r_pend_act <= new_act;
            r_pend_seq <= new_seq;
            r_pend_len <= new_len;
        end
        if ((i_cmd.emit && r_pend_valid) || i_cmd.flush) begin
            r_out_act  <= r_pend_act;
            r_out_seq  <= r_pend_seq;
            r_out_len  <= r_pend_len;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out_act;
    assign o_seq            = r_out_seq;
    assign o_payload_length = r_out_len;
    assign o_last           = r_out_last;

endmodule

@@ hw/rtl/selective_repeat_sender_window_top.sv @@
// Sequencing: a start item goes from idle through the decide state back to idle;
// a poll or ack item runs up to three modulo passes (each a start plus the
// 17-step remainder unit) plus a step per window slot scanned or slid, and
// output stalls can hold it longer. One item at a time; results leave through
// a one-deep pending stage and an output register, stalling only when both are full.
// Reset (i_rst_n low, synchronous): registers to 4/1000/0, window cleared.
module selective_repeat_sender_window_top
    import srsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_time,
    input  logic [SEQ_W-1:0]   i_ack_seq,
    input  logic [2:0]         i_ack_tag,
    input  logic               i_ack_checksum_ok,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_action,
    output logic [SEQ_W-1:0]   o_seq,
    output logic [LEN_W-1:0]   o_payload_length,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srsw_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_now_time        (i_now_time),
        .i_ack_seq         (i_ack_seq),
        .i_ack_tag         (i_ack_tag),
        .i_ack_checksum_ok (i_ack_checksum_ok),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_action          (o_action),
        .o_seq             (o_seq),
        .o_payload_length  (o_payload_length),
        .o_last            (o_last)
    );

endmodule

@@ dv/selective_repeat_sender_window_checker.sv @@
module selective_repeat_sender_window_checker
    import srsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_time,
    input  logic [SEQ_W-1:0]   i_ack_seq,
    input  logic [2:0]         i_ack_tag,
    input  logic               i_ack_checksum_ok,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_action,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic [LEN_W-1:0]   i_payload_length,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_action          action;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_packet;

    t_packet expected_packets[$];

    logic [WIN_W-1:0]   win_reg;
    logic [31:0]        timeout_reg;
    logic [BYTES_W-1:0] bytes_reg;

    int                 base_seq;
    int unsigned        next_seq;
    logic               acked_mark [MAX_WINDOW];
    logic               timer_on [MAX_WINDOW];
    logic [31:0]        stamp [MAX_WINDOW];
    logic               done_sent;

    assign o_pending = expected_packets.size();

    function automatic void clear_window();
        base_seq = -1;
        next_seq = 0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            acked_mark[i] = 1'b0;
            timer_on[i] = 1'b0;
            stamp[i] = '0;
        end
        done_sent = 1'b0;
    endfunction

    function automatic void emit(ref t_packet batch[$], input t_action act,
                                 input int unsigned seq, input int unsigned len);
        t_packet p;
        p.action = act;
        p.seq = seq[SEQ_W-1:0];
        p.len = len[LEN_W-1:0];
        p.last = 1'b0;
        batch.push_back(p);
    endfunction

    function automatic void predict_window(t_op op, logic [31:0] now,
                                           logic [15:0] aseq, logic [2:0] tag, logic ck);
        t_packet batch[$];
        int unsigned w, bytes, segs, acked, s, len;
        if (op == OP_NONE) return;
        if (op == OP_START) begin
            clear_window();
            return;
        end
        w = win_reg;
        if (w < 1) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        bytes = (bytes_reg > BYTES_CAP) ? BYTES_CAP : bytes_reg;
        segs = bytes / 1024 + ((bytes % 1024) != 0);
        acked = base_seq + 1;
        if (acked == segs) begin
            if (!done_sent) begin
                emit(batch, ACT_DONE, 0, 0);
                done_sent = 1'b1;
            end
        end else begin
            if (next_seq < segs && next_seq - acked < w) begin
                len = (next_seq == segs - 1) ? bytes - (segs - 1) * 1024 : 1024;
                s = next_seq % w;
                emit(batch, ACT_SEND, next_seq, len);
                stamp[s] = now;
                timer_on[s] = 1'b1;
                next_seq++;
            end
            if (op == OP_ACK) begin
                if (tag == TAG_ACK && ck) begin
                    if (aseq >= acked && aseq < next_seq) begin
                        s = aseq % w;
                        acked_mark[s] = 1'b1;
                        timer_on[s] = 1'b0;
                    end
                    for (int i = 0; i < w && acked < next_seq && acked_mark[acked % w]; i++) begin
                        acked_mark[acked % w] = 1'b0;
                        acked++;
                    end
                    base_seq = int'(acked) - 1;
                    if (acked == segs && !done_sent) begin
                        emit(batch, ACT_DONE, 0, 0);
                        done_sent = 1'b1;
                    end
                end
            end else begin
                for (int unsigned i = 0; i < w; i++) begin
                    s = (acked + i) % w;
                    if (timer_on[s] && (now - stamp[s]) > timeout_reg) begin
                        emit(batch, ACT_RETX, acked + i, 0);
                        stamp[s] = now;
                    end
                end
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected_packets.push_back(batch[i]);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_packet exp_p;
        if (!i_rst_n) begin
            win_reg = 6'd4;
            timeout_reg = 32'd1000;
            bytes_reg = '0;
            clear_window();
            expected_packets.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WINDOW:  win_reg = i_cfg_data[WIN_W-1:0];
                    REG_TIMEOUT: timeout_reg = i_cfg_data;
                    REG_BYTES:   bytes_reg = i_cfg_data[BYTES_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_packets.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction act=%0d seq=%0d",
                                              i_action, i_seq));
                end else begin
                    exp_p = expected_packets.pop_front();
                    if (i_action != exp_p.action)
                        report_mismatch($sformatf("action %0d, want %0d",
                                                  i_action, exp_p.action));
                    if (i_seq != exp_p.seq)
                        report_mismatch($sformatf("seq %0d, want %0d", i_seq, exp_p.seq));
                    if (i_payload_length != exp_p.len)
                        report_mismatch($sformatf("length %0d, want %0d",
                                                  i_payload_length, exp_p.len));
                    if (i_last != exp_p.last)
                        report_mismatch($sformatf("last %0d, want %0d", i_last, exp_p.last));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_window(t_op'(i_op), i_now_time, i_ack_seq, i_ack_tag,
                               i_ack_checksum_ok);
        end
    end

endmodule

@@ dv/selective_repeat_sender_window_top_tb.sv @@
module selective_repeat_sender_window_top_tb;
    import srsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = REG_WINDOW;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_op = OP_POLL;
    logic [31:0]        i_now_time = '0;
    logic [SEQ_W-1:0]   i_ack_seq = '0;
    logic [2:0]         i_ack_tag = '0;
    logic               i_ack_checksum_ok = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_action;
    logic [SEQ_W-1:0]   o_seq;
    logic [LEN_W-1:0]   o_payload_length;
    logic               o_last;

    int                 errors;
    int                 pending;
    int                 idle_mode;
    int                 quiet_cycles;
    logic [31:0]        clock_now;
    logic [SEQ_W-1:0]   sent_seqs[$];

    always #5 i_clk = ~i_clk;

    selective_repeat_sender_window_top u_top (.*);

    selective_repeat_sender_window_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_op, .i_now_time, .i_ack_seq,
        .i_ack_tag, .i_ack_checksum_ok,
        .i_out_valid(o_out_valid), .i_out_ready, .i_action(o_action), .i_seq(o_seq),
        .i_payload_length(o_payload_length), .i_last(o_last),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver side stalls
    always @(posedge i_clk) begin
        if (idle_mode == 2)
            i_out_ready <= ($urandom_range(99) >= 69);
        else if (idle_mode == 3)
            i_out_ready <= ($urandom_range(99) >= 13);
        else
            i_out_ready <= 1'b1;
    end

    // track sent sequence numbers so acks can hit the window
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready && o_action == ACT_SEND)
            sent_seqs.push_back(o_seq);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic issue(t_op op, logic [31:0] now, logic [15:0] aseq,
                         logic [2:0] tag, logic ck);
        int gap;
        i_op <= op;
        i_now_time <= now;
        i_ack_seq <= aseq;
        i_ack_tag <= tag;
        i_ack_checksum_ok <= ck;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_START) sent_seqs.delete();
        gap = 0;
        if (idle_mode == 1 && $urandom_range(99) < 69) gap = $urandom_range(1, 4);
        if (idle_mode == 3 && $urandom_range(99) < 13) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_quiet();
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic good_ack();
        logic [15:0] a;
        a = (sent_seqs.size() > 0) ? sent_seqs[$urandom_range(sent_seqs.size() - 1)]
                                   : 16'(0);
        issue(OP_ACK, clock_now, a, 3'b010, 1'b1);
    endtask

    task automatic noisy_item();
        issue(t_op'($urandom_range(3)), $urandom, 16'($urandom), 3'($urandom),
              1'($urandom));
    endtask

    initial begin
        idle_mode = 0;
        quiet_cycles = 0;
        clock_now = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: empty transfer completes at once
        issue(OP_POLL, 32'd0, 16'd0, 3'd0, 1'b0);
        issue(OP_POLL, 32'd5, 16'd0, 3'd0, 1'b0);
        issue(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 1'b1);

        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_BYTES, 32'd1);
        write_reg(REG_TIMEOUT, 32'd1);
        issue(OP_START, 32'd0, 16'd0, 3'd0, 1'b0);
        issue(OP_POLL, 32'd0, 16'd0, 3'd0, 1'b0);
        issue(OP_POLL, 32'd2, 16'd0, 3'd0, 1'b0);
        issue(OP_ACK, 32'd2, 16'd0, 3'd3, 1'b1);
        issue(OP_ACK, 32'd2, 16'd0, 3'b010, 1'b0);
        issue(OP_ACK, 32'd2, 16'hFFFF, 3'b010, 1'b1);
        issue(OP_ACK, 32'd2, 16'd0, 3'b010, 1'b1);
        issue(OP_POLL, 32'd9, 16'd0, 3'd0, 1'b0);

        write_reg(REG_WINDOW, 32'd63);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_BYTES, 32'h07FF_FFFF);
        issue(OP_START, 32'd0, 16'd0, 3'd0, 1'b0);
        for (int i = 0; i < 6; i++) issue(OP_POLL, 32'hFFFF_FFF0 + i, 16'd0, 3'd4, 1'b1);
        write_reg(REG_BYTES, 32'd67108864);
        write_reg(REG_WINDOW, 32'd32);
        write_reg(REG_TIMEOUT, 32'd0);
        issue(OP_POLL, 32'd20, 16'd0, 3'd0, 1'b0);
        write_reg(REG_BYTES, 32'd2049);
        write_reg(REG_WINDOW, 32'd1);
        issue(OP_START, 32'd0, 16'd0, 3'd0, 1'b0);
        issue(OP_POLL, 32'd3, 16'd0, 3'd0, 1'b0);

        for (int phase = 0; phase < 12; phase++) begin
            idle_mode = phase % 4;
            case ($urandom_range(5))
                0: write_reg(REG_WINDOW, (phase % 2) ? 32'd32 : 32'd1);
                1: write_reg(REG_WINDOW, $urandom_range(33, 63));
                default: write_reg(REG_WINDOW, $urandom_range(0, 32));
            endcase
            if ($urandom_range(7) == 0)
                write_reg(REG_TIMEOUT, $urandom);
            else
                write_reg(REG_TIMEOUT, $urandom_range(1, 150));
            if ($urandom_range(9) == 0)
                write_reg(REG_BYTES, $urandom);
            else
                write_reg(REG_BYTES, $urandom_range(0, 24 * 1024));
            clock_now = (phase % 3 == 0) ? $urandom : 32'hFFFF_FF00;
            issue(OP_START, clock_now, 16'($urandom), 3'($urandom), 1'($urandom));
            for (int i = 0; i < 38; i++) begin
                clock_now += $urandom_range(0, 40);
                case ($urandom_range(9))
                    0, 1, 2, 3: issue(OP_POLL, clock_now, 16'($urandom), 3'($urandom),
                                      1'($urandom));
                    4, 5, 6, 7: good_ack();
                    8: issue(OP_ACK, clock_now, 16'($urandom_range(0, 40)),
                             3'($urandom), 1'($urandom));
                    default: noisy_item();
                endcase
            end
        end

        idle_mode = 0;
        wait_quiet();
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
